// ===== rtl/core/tsp_pkg.sv =====
// Shared types, action codes and the melody table of the tone sequence player.
package tsp_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;
    localparam int FREQ_W        = 12;
    localparam int DUR_W         = 9;
    localparam int SEL_W         = 3;
    localparam int IDX_W         = 3;
    localparam int LEN_W         = 4;
    localparam int NUM_MELODIES  = 6;
    localparam int ROM_STEPS     = 7;
    localparam int MAX_STEPS     = 7;

    localparam logic [1:0] ACT_PLAY = 2'd0;
    localparam logic [1:0] ACT_STOP = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [SEL_W-1:0] sound;
        logic [NOW_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic              tone_on;
        logic [FREQ_W-1:0] tone_freq;
        logic              busy_res;
        logic              step_started;
    } t_result;

    typedef struct packed {
        logic [FREQ_W-1:0] hz;
        logic [DUR_W-1:0]  ms;
    } t_step;

    // Number of steps of a melody, capped at MAX_STEPS.
    function automatic logic [LEN_W-1:0] melody_len(input logic [SEL_W-1:0] sel);
        logic [LEN_W-1:0] n;
        case (sel)
            3'd0:    n = LEN_W'(1);
            3'd1:    n = LEN_W'(2);
            3'd2:    n = LEN_W'(2);
            3'd3:    n = LEN_W'(7);
            3'd4:    n = LEN_W'(3);
            3'd5:    n = LEN_W'(3);
            default: n = LEN_W'(0);
        endcase
        if (n > LEN_W'(MAX_STEPS)) begin
            n = LEN_W'(MAX_STEPS);
        end
        return n;
    endfunction

    // Melody table: frequency in Hz (0 is a rest) and duration in ms.
    function automatic t_step rom_step(input logic [SEL_W-1:0] sel,
                                       input logic [IDX_W-1:0] idx);
        t_step s;
        s = '0;
        case ({sel, idx})
            {3'd0, 3'd0}: s = '{hz: 12'd3500, ms: 9'd10};
            {3'd1, 3'd0}: s = '{hz: 12'd2200, ms: 9'd40};
            {3'd1, 3'd1}: s = '{hz: 12'd3000, ms: 9'd70};
            {3'd2, 3'd0}: s = '{hz: 12'd500,  ms: 9'd100};
            {3'd2, 3'd1}: s = '{hz: 12'd350,  ms: 9'd160};
            {3'd3, 3'd0}: s = '{hz: 12'd1800, ms: 9'd90};
            {3'd3, 3'd1}: s = '{hz: 12'd0,    ms: 9'd120};
            {3'd3, 3'd2}: s = '{hz: 12'd1800, ms: 9'd90};
            {3'd3, 3'd3}: s = '{hz: 12'd0,    ms: 9'd120};
            {3'd3, 3'd4}: s = '{hz: 12'd1800, ms: 9'd90};
            {3'd3, 3'd5}: s = '{hz: 12'd0,    ms: 9'd120};
            {3'd3, 3'd6}: s = '{hz: 12'd2800, ms: 9'd350};
            {3'd4, 3'd0}: s = '{hz: 12'd900,  ms: 9'd70};
            {3'd4, 3'd1}: s = '{hz: 12'd700,  ms: 9'd70};
            {3'd4, 3'd2}: s = '{hz: 12'd500,  ms: 9'd110};
            {3'd5, 3'd0}: s = '{hz: 12'd1400, ms: 9'd60};
            {3'd5, 3'd1}: s = '{hz: 12'd1900, ms: 9'd60};
            {3'd5, 3'd2}: s = '{hz: 12'd2600, ms: 9'd90};
            default:      s = '0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/tsp_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface tsp_in_if
    import tsp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       action;
    logic [SEL_W-1:0] sound;
    logic [NOW_W-1:0] now;

    modport source (output valid, output action, output sound, output now, input ready);
    modport sink   (input valid, input action, input sound, input now, output ready);
endinterface

interface tsp_out_if
    import tsp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              tone_on;
    logic [FREQ_W-1:0] tone_freq;
    logic              busy_res;
    logic              step_started;

    modport source (output valid, output tone_on, output tone_freq, output busy_res,
                    output step_started, input ready);
    modport sink   (input valid, input tone_on, input tone_freq, input busy_res,
                    input step_started, output ready);
endinterface

// ===== rtl/core/tsp_input_reg.sv =====
// Input register stage: capture one item, hold it until the engine takes it.
module tsp_input_reg
    import tsp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    tsp_in_if.sink i_item,
    input  logic   i_advance,
    output logic   o_valid,
    output t_item  o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    assign i_item.ready = !r_valid || i_advance;
    assign w_load       = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= '{action: i_item.action, sound: i_item.sound, now: i_item.now};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/core/tsp_engine.sv =====
// Player state and next-state logic: one item is applied per firing cycle.
module tsp_engine
    import tsp_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    logic                 r_playing,  n_playing;
    logic [SEL_W-1:0]     r_sel,      n_sel;
    logic [IDX_W-1:0]     r_idx,      n_idx;
    logic [TIME_BITS-1:0] r_deadline, n_deadline;
    logic                 r_armed,    n_armed;
    logic                 r_enable,   n_enable;
    logic [FREQ_W-1:0]    r_hz,       n_hz;

    logic [TIME_BITS-1:0] w_now;
    logic [IDX_W-1:0]     w_idx;
    t_step                w_step;
    logic                 w_started;

    assign w_now  = i_item.now[TIME_BITS-1:0];
    // Advance the step only once the current one has been started.
    assign w_idx  = r_armed ? IDX_W'(r_idx + IDX_W'(1)) : r_idx;
    assign w_step = rom_step(r_sel, w_idx);

    always_comb begin
        n_playing  = r_playing;
        n_sel      = r_sel;
        n_idx      = r_idx;
        n_deadline = r_deadline;
        n_armed    = r_armed;
        n_enable   = r_enable;
        n_hz       = r_hz;
        w_started  = 1'b0;
        case (i_item.action)
            ACT_PLAY: begin
                if (i_item.sound < SEL_W'(NUM_MELODIES)) begin
                    n_sel     = i_item.sound;
                    n_idx     = '0;
                    n_playing = 1'b1;
                    n_armed   = 1'b0;
                end
            end
            ACT_STOP: begin
                n_playing = 1'b0;
                n_enable  = 1'b0;
                n_hz      = '0;
                w_started = 1'b1;
            end
            ACT_TICK: begin
                if (r_playing && !(r_armed && (w_now < r_deadline))) begin
                    n_idx     = w_idx;
                    w_started = 1'b1;
                    if ({1'b0, w_idx} >= melody_len(r_sel) ||
                        {1'b0, w_idx} >= LEN_W'(ROM_STEPS)) begin
                        n_playing = 1'b0;
                        n_enable  = 1'b0;
                        n_hz      = '0;
                    end else begin
                        n_enable   = (w_step.hz != '0);
                        n_hz       = w_step.hz;
                        n_deadline = w_now + TIME_BITS'(w_step.ms);
                        n_armed    = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing  <= 1'b0;
            r_sel      <= '0;
            r_idx      <= '0;
            r_deadline <= '0;
            r_armed    <= 1'b0;
            r_enable   <= 1'b0;
            r_hz       <= '0;
        end else if (i_fire) begin
            r_playing  <= n_playing;
            r_sel      <= n_sel;
            r_idx      <= n_idx;
            r_deadline <= n_deadline;
            r_armed    <= n_armed;
            r_enable   <= n_enable;
            r_hz       <= n_hz;
        end
    end

    assign o_result.tone_on      = n_enable;
    assign o_result.tone_freq    = n_enable ? n_hz : '0;
    assign o_result.busy_res     = n_playing;
    assign o_result.step_started = w_started;

endmodule

// ===== rtl/core/tone_sequence_player.sv =====
// Top level of the tone sequence player: input stage, engine and result register.
// An accepted item passes through the input register and then the result register;
// it waits in the input register while the result slot is full. Throughput: one item
// per cycle while results are taken; the engine is one table read, compare and add.
// Reset (i_rst_n low at a clock edge, synchronous): both stages empty, player
// stopped, tone silent, no melody step armed.
module tone_sequence_player
    import tsp_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tsp_in_if.sink   i_item,
    tsp_out_if.source o_res
);

    logic    w_in_valid;
    t_item   w_in_item;
    logic    w_out_free;
    logic    w_fire;
    t_result w_result;

    logic    r_out_valid;
    t_result r_out;

    // The result slot is free when empty or being taken this cycle.
    assign w_out_free = !r_out_valid || o_res.ready;
    // Apply the held item to the player state when its result has room.
    assign w_fire     = w_in_valid && w_out_free;

    // Capture items; hold one until the engine consumes it.
    tsp_input_reg u_input_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (w_out_free),
        .o_valid   (w_in_valid),
        .o_item    (w_in_item)
    );

    // Play/stop/tick decode, melody table, deadline compare and add.
    tsp_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_in_item),
        .o_result (w_result)
    );

    // Result register: load on fire, drop once taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.tone_on      = r_out.tone_on;
    assign o_res.tone_freq    = r_out.tone_freq;
    assign o_res.busy_res     = r_out.busy_res;
    assign o_res.step_started = r_out.step_started;

endmodule

// ===== tb/tsp_checker.sv =====
`timescale 1ns / 100ps
// Checker for the tone sequence player: watches both channels, predicts results, compares.
module tsp_checker
    import tsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tsp_in_if    i_item,
    tsp_out_if   i_res,
    output int   o_errors,
    output int   o_pending,
    output int   o_items,
    output int   o_results,
    output int   o_steps,
    output int   o_tones
);

    // Melody table as the player should know it: pitch (0 is a rest) and length in ms.
    logic [FREQ_W-1:0] note_hz [NUM_MELODIES][ROM_STEPS];
    logic [DUR_W-1:0]  note_ms [NUM_MELODIES][ROM_STEPS];
    int unsigned       note_cnt [NUM_MELODIES];

    // Player state as predicted.
    logic              playing;
    logic [SEL_W-1:0]  tune;
    logic [IDX_W-1:0]  note_idx;
    logic [NOW_W-1:0]  due_ms;
    logic              due_armed;
    logic              buzz_en;
    logic [FREQ_W-1:0] buzz_hz;

    t_result expected_tones [$];
    t_result want;
    t_result got;
    int      mism;

    task automatic set_note(input int m, input int i, input int hz, input int ms);
        note_hz[m][i] = FREQ_W'(hz);
        note_ms[m][i] = DUR_W'(ms);
    endtask

    initial begin
        for (int m = 0; m < NUM_MELODIES; m++) begin
            for (int i = 0; i < ROM_STEPS; i++) begin
                set_note(m, i, 0, 0);
            end
        end
        note_cnt = '{1, 2, 2, 7, 3, 3};
        set_note(0, 0, 3500, 10);
        set_note(1, 0, 2200, 40);  set_note(1, 1, 3000, 70);
        set_note(2, 0, 500, 100);  set_note(2, 1, 350, 160);
        set_note(3, 0, 1800, 90);  set_note(3, 1, 0, 120);   set_note(3, 2, 1800, 90);
        set_note(3, 3, 0, 120);    set_note(3, 4, 1800, 90); set_note(3, 5, 0, 120);
        set_note(3, 6, 2800, 350);
        set_note(4, 0, 900, 70);   set_note(4, 1, 700, 70);  set_note(4, 2, 500, 110);
        set_note(5, 0, 1400, 60);  set_note(5, 1, 1900, 60); set_note(5, 2, 2600, 90);
    end

    function automatic void hush();
        playing = 1'b0;
        buzz_en = 1'b0;
        buzz_hz = '0;
    endfunction

    // Apply one item to the predicted player and return the result it should produce.
    function automatic t_result advance_player(input t_item it);
        t_result     r;
        logic        started;
        int unsigned len;
        started = 1'b0;
        case (it.action)
            ACT_PLAY: begin
                if (it.sound < NUM_MELODIES) begin
                    tune      = it.sound;
                    note_idx  = '0;
                    playing   = 1'b1;
                    due_armed = 1'b0;
                end
            end
            ACT_STOP: begin
                hush();
                started = 1'b1;
            end
            ACT_TICK: begin
                if (playing && !(due_armed && it.now < due_ms)) begin
                    if (due_armed) begin
                        note_idx = note_idx + 1'b1;
                    end
                    len = note_cnt[tune];
                    if (len > MAX_STEPS) begin
                        len = MAX_STEPS;
                    end
                    if (note_idx >= len) begin
                        hush();
                    end else begin
                        buzz_en   = (note_hz[tune][note_idx] != '0);
                        buzz_hz   = note_hz[tune][note_idx];
                        due_ms    = it.now + NOW_W'(note_ms[tune][note_idx]);
                        due_armed = 1'b1;
                    end
                    started = 1'b1;
                end
            end
            default: ;
        endcase
        r.tone_on      = buzz_en;
        r.tone_freq    = buzz_en ? buzz_hz : '0;
        r.busy_res     = playing;
        r.step_started = started;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            playing   = 1'b0;
            tune      = '0;
            note_idx  = '0;
            due_ms    = '0;
            due_armed = 1'b0;
            buzz_en   = 1'b0;
            buzz_hz   = '0;
            expected_tones.delete();
            o_errors  <= 0;
            o_pending <= 0;
            o_items   <= 0;
            o_results <= 0;
            o_steps   <= 0;
            o_tones   <= 0;
        end else begin
            mism = 0;
            // Results leave only after their item has passed the input and result registers, so pop before push.
            if (i_res.valid && i_res.ready) begin
                got.tone_on      = i_res.tone_on;
                got.tone_freq    = i_res.tone_freq;
                got.busy_res     = i_res.busy_res;
                got.step_started = i_res.step_started;
                o_results <= o_results + 1;
                if (expected_tones.size() == 0) begin
                    $error("result with no item pending: %p", got);
                    mism++;
                end else begin
                    want = expected_tones.pop_front();
                    if (got.tone_on !== want.tone_on) begin
                        $error("tone_on: expected %0d, got %0d", want.tone_on, got.tone_on);
                        mism++;
                    end
                    if (got.tone_freq !== want.tone_freq) begin
                        $error("tone_freq: expected %0d, got %0d",
                               want.tone_freq, got.tone_freq);
                        mism++;
                    end
                    if (got.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
                        mism++;
                    end
                    if (got.step_started !== want.step_started) begin
                        $error("step_started: expected %0d, got %0d",
                               want.step_started, got.step_started);
                        mism++;
                    end
                    if (want.step_started) begin
                        o_steps <= o_steps + 1;
                    end
                    if (want.tone_on) begin
                        o_tones <= o_tones + 1;
                    end
                end
            end
            o_errors <= o_errors + mism;
            if (i_item.valid && i_item.ready) begin
                expected_tones.push_back(advance_player('{action: i_item.action,
                                                          sound:  i_item.sound,
                                                          now:    i_item.now}));
                o_items <= o_items + 1;
            end
            o_pending <= expected_tones.size();
        end
    end

endmodule

// ===== tb/tb_tone_sequence_player.sv =====
`timescale 1ns / 100ps
// Testbench top for the tone sequence player: clock, reset, stimulus, back-pressure, verdict.
module tb_tone_sequence_player;
    import tsp_pkg::*;

    // Action code the block treats as a no-op.
    localparam logic [1:0] ACT_NOP    = 2'd3;
    localparam int         ITEM_GOAL  = 1600;
    localparam int         CYCLE_CAP  = 800_000;
    localparam int         DRAIN_WAIT = 16;

    logic i_clk;
    logic i_rst_n;

    tsp_in_if  item_ch ();
    tsp_out_if res_ch ();

    int errors;
    int pending;
    int items_seen;
    int results_seen;
    int step_events;
    int tone_results;

    tone_sequence_player DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch)
    );

    tsp_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_ch),
        .i_res     (res_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_items   (items_seen),
        .o_results (results_seen),
        .o_steps   (step_events),
        .o_tones   (tone_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: end the run if it hangs.
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb_tone_sequence_player: done, errors");
            $finish;
        end
    end

    // Alternate between stretches with random idling and stretches with none.
    logic calm = 1'b0;
    int   calm_left = 200;
    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            calm      <= !calm;
            calm_left <= $urandom_range(50, 400);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    // Idle length: mostly a few cycles, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Result back-pressure: drop ready for random stalls.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            res_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25) begin
                stall_left <= idle_len();
            end
        end
    end

    // Sender: time of the simulated millisecond clock and count of items that do something.
    logic [NOW_W-1:0] clock_ms;
    int               live_items = 0;

    // Present one item, optionally after an idle gap, and hold it until accepted.
    task automatic send_item(input logic [1:0] act, input logic [SEL_W-1:0] snd,
                             input logic [NOW_W-1:0] t);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 30) begin
            gap = idle_len();
        end
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.action <= act;
        item_ch.sound  <= snd;
        item_ch.now    <= t;
        do @(posedge i_clk); while (!item_ch.ready);
        if (!(act == ACT_NOP || (act == ACT_PLAY && snd >= NUM_MELODIES))) begin
            live_items++;
        end
    endtask

    // Tick with the millisecond clock moved forward by a random step.
    task automatic tick_forward();
        int r;
        int deltas [8];
        deltas = '{60, 70, 90, 100, 110, 120, 160, 350};
        r = $urandom_range(0, 99);
        if (r < 25) begin
            clock_ms = clock_ms + $urandom_range(0, 20);      // often early
        end else if (r < 60) begin
            clock_ms = clock_ms + deltas[$urandom_range(0, 7)]; // often lands on the deadline
        end else begin
            clock_ms = clock_ms + $urandom_range(0, 400);
        end
        send_item(ACT_TICK, SEL_W'($urandom), clock_ms);
    endtask

    // One play request followed by a run of ticks, with stops, restarts and noise mixed in.
    task automatic play_sequence();
        int n;
        int r;
        if ($urandom_range(0, 9) == 0) begin
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);  // let deadlines wrap
        end
        if ($urandom_range(0, 9) == 0) begin
            send_item(ACT_PLAY, SEL_W'($urandom_range(NUM_MELODIES, 7)), $urandom);
        end else begin
            send_item(ACT_PLAY, SEL_W'($urandom_range(0, NUM_MELODIES - 1)), $urandom);
        end
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_item(ACT_STOP, SEL_W'($urandom), $urandom);
            end else if (r < 8) begin
                send_item(ACT_PLAY, SEL_W'($urandom_range(0, 7)), $urandom);
            end else if (r < 10) begin
                send_item(ACT_NOP, SEL_W'($urandom), $urandom);
            end else if (r < 12) begin
                clock_ms = $urandom;                          // arbitrary clock jump
                send_item(ACT_TICK, SEL_W'($urandom), clock_ms);
            end else begin
                tick_forward();
            end
        end
    endtask

    initial begin
        item_ch.valid  <= 1'b0;
        item_ch.action <= ACT_TICK;
        item_ch.sound  <= '0;
        item_ch.now    <= '0;
        i_rst_n        <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle tick, stop while idle, unknown action, unknown melodies.
        send_item(ACT_TICK, 3'd0, 32'h0000_0000);
        send_item(ACT_STOP, 3'd7, 32'hFFFF_FFFF);
        send_item(ACT_NOP,  3'd7, 32'hFFFF_FFFF);
        send_item(ACT_PLAY, 3'd6, 32'h0000_0000);
        send_item(ACT_PLAY, 3'd7, 32'hFFFF_FFFF);
        // Single-note melody: start, early tick, tick exactly at the deadline ends it.
        send_item(ACT_PLAY, 3'd0, 32'h0);
        send_item(ACT_TICK, 3'd0, 32'd100);
        send_item(ACT_TICK, 3'd0, 32'd105);
        send_item(ACT_TICK, 3'd0, 32'd110);
        // Deadlines that wrap past the top of the clock.
        send_item(ACT_PLAY, 3'd1, 32'h0);
        send_item(ACT_TICK, 3'd0, 32'hFFFF_FFF0);
        send_item(ACT_TICK, 3'd0, 32'hFFFF_FFF1);
        send_item(ACT_TICK, 3'd0, 32'h0000_0000);
        send_item(ACT_TICK, 3'd0, 32'h0000_0037);
        // Play while sounding holds the old tone until the next tick; then stop.
        send_item(ACT_PLAY, 3'd2, 32'h0);
        send_item(ACT_TICK, 3'd0, 32'd1000);
        send_item(ACT_PLAY, 3'd4, 32'h0);
        send_item(ACT_TICK, 3'd0, 32'd1001);
        send_item(ACT_STOP, 3'd0, 32'h0);
        // Long melody into its rests.
        send_item(ACT_PLAY, 3'd3, 32'h0);
        send_item(ACT_TICK, 3'd0, 32'd2000);
        send_item(ACT_TICK, 3'd0, 32'd3000);
        send_item(ACT_TICK, 3'd0, 32'd4000);

        // Random sequences until enough live items have gone in.
        clock_ms = $urandom;
        while (live_items < ITEM_GOAL) begin
            play_sequence();
        end
        item_ch.valid <= 1'b0;

        // Drain: wait for every expected result, then a few more cycles for strays.
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d items, %0d results checked", items_seen, results_seen);
        $display("%0d step starts or stops, %0d results with the buzzer on",
                 step_events, tone_results);
        if (errors == 0) begin
            $display("tb_tone_sequence_player: done, clean");
        end else begin
            $display("tb_tone_sequence_player: done, errors");
        end
        $finish;
    end

endmodule

// ===== tone_sequence_player.f =====
rtl/core/tsp_pkg.sv
rtl/core/tsp_if.sv
rtl/core/tsp_input_reg.sv
rtl/core/tsp_engine.sv
rtl/core/tone_sequence_player.sv
tb/tsp_checker.sv
tb/tb_tone_sequence_player.sv
